// ===== rtl/bmm_pkg.sv =====
// Shared constants and codes for the blocked matrix multiply core.
// Used by bmm_mac and blocked_matrix_multiply_core; depends on nothing.
`default_nettype none

package bmm_pkg;

  // Matrix geometry: a square DIM x DIM matrix, one word per element.
  localparam int DIM    = 64;
  localparam int IDX_W  = $clog2(DIM);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int END_W  = IDX_W + 1;
  localparam int WORD_W = 32;

  // Block edge register.
  localparam int EDGE_W = 7;
  localparam logic [EDGE_W-1:0] EDGE_RESET = EDGE_W'(32);
  localparam int SUM_W = ((IDX_W > EDGE_W) ? IDX_W : EDGE_W) + 1;

  // Action codes carried on tuser.
  localparam int ACT_W = 2;
  localparam logic [ACT_W-1:0] ACT_WR_A = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WR_B = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CMP  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_RD_C = 2'd3;

  // Input tdata layout: row, col, value, padded to whole bytes.
  localparam int IN_FIELDS_W = 2 * IDX_W + WORD_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== rtl/bmm_mac.sv =====
// Shared multiply-accumulate unit: one registered 32x32 product, one accumulator.
// Depends on bmm_pkg for the word width.
`default_nettype none

module bmm_mac (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       clr,
  input  wire logic                       in_valid,
  input  wire logic [bmm_pkg::WORD_W-1:0] a,
  input  wire logic [bmm_pkg::WORD_W-1:0] b,
  output logic      [bmm_pkg::WORD_W-1:0] acc
);

  logic [2*bmm_pkg::WORD_W-1:0] full_prod;
  logic [bmm_pkg::WORD_W-1:0]   prod_r;
  logic                         prod_v_r;
  logic [bmm_pkg::WORD_W-1:0]   acc_r;

  // Only the low word of the product matters, since sums wrap modulo 2^32.
  assign full_prod = a * b;

  // Product stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= in_valid;
    end
    prod_r <= full_prod[bmm_pkg::WORD_W-1:0];
  end

  // Accumulate stage; a clear wins over a late product of the previous element.
  always_ff @(posedge clk) begin
    if (clr) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + prod_r;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// ===== rtl/blocked_matrix_multiply_core.sv =====
// A write of A or B answers in the cycle after its beat; a read of C answers after the
// registered C read and the S_RDC state. A compute beat works through the elements of
// the clipped block one at a time, since there is one shared multiplier and a single
// read port on each matrix memory. One item is in work at a time.
// Reset (rst_n, synchronous, active low) clears control state and sets block_edge to
// 32; the A, B and C memories keep whatever they hold until written.
// Depends on bmm_pkg and bmm_mac.
`default_nettype none

module blocked_matrix_multiply_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input stream.
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [bmm_pkg::IN_DATA_W-1:0] in_tdata,  // row[5:0], col[11:6], value[43:12]
  input  wire logic [bmm_pkg::ACT_W-1:0]     in_tuser,  // action[1:0]
  // Result stream.
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [bmm_pkg::WORD_W-1:0]    out_tdata, // read_value[31:0]
  output logic      [bmm_pkg::ACT_W-1:0]     out_tuser, // kind[1:0]
  // Block edge register write.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bmm_pkg::EDGE_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_RDC, S_MAC, S_DRAIN} state_t;

  localparam logic [bmm_pkg::IDX_W-1:0] K_LAST = bmm_pkg::IDX_W'(bmm_pkg::DIM - 1);
  localparam logic [bmm_pkg::SUM_W-1:0] DIM_S  = bmm_pkg::SUM_W'(bmm_pkg::DIM);

  // Input fields.
  logic [bmm_pkg::IDX_W-1:0]  in_row;
  logic [bmm_pkg::IDX_W-1:0]  in_col;
  logic [bmm_pkg::WORD_W-1:0] in_value;
  logic [bmm_pkg::ACT_W-1:0]  in_action;
  logic                       in_acc;

  assign in_row    = in_tdata[bmm_pkg::IDX_W-1:0];
  assign in_col    = in_tdata[2*bmm_pkg::IDX_W-1:bmm_pkg::IDX_W];
  assign in_value  = in_tdata[2*bmm_pkg::IDX_W+bmm_pkg::WORD_W-1:2*bmm_pkg::IDX_W];
  assign in_action = in_tuser;

  // Control and output registers.
  state_t                     st_r, st_nxt;
  logic [bmm_pkg::EDGE_W-1:0] edge_r, edge_nxt;
  logic [bmm_pkg::IDX_W-1:0]  r_r, r_nxt;
  logic [bmm_pkg::IDX_W-1:0]  c_r, c_nxt;
  logic [bmm_pkg::IDX_W-1:0]  k_r, k_nxt;
  logic [bmm_pkg::IDX_W-1:0]  left_r, left_nxt;
  logic [bmm_pkg::END_W-1:0]  rend_r, rend_nxt;
  logic [bmm_pkg::END_W-1:0]  cend_r, cend_nxt;
  logic [1:0]                 drain_r, drain_nxt;
  logic                       rd_v_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [bmm_pkg::ACT_W-1:0]  out_kind_r, out_kind_nxt;
  logic [bmm_pkg::WORD_W-1:0] out_val_r, out_val_nxt;

  // Memory ports.
  logic [bmm_pkg::WORD_W-1:0] mem_a [bmm_pkg::DIM*bmm_pkg::DIM];
  logic [bmm_pkg::WORD_W-1:0] mem_b [bmm_pkg::DIM*bmm_pkg::DIM];
  logic [bmm_pkg::WORD_W-1:0] mem_c [bmm_pkg::DIM*bmm_pkg::DIM];
  logic [bmm_pkg::WORD_W-1:0] a_rd_r, b_rd_r, c_rd_r;
  logic                       a_we, b_we, c_we;
  logic [bmm_pkg::ADDR_W-1:0] in_addr;
  logic [bmm_pkg::ADDR_W-1:0] a_raddr, b_raddr, rc_addr;

  // Sequencer helpers.
  logic                       out_free;
  logic                       issue;
  logic                       mac_clr;
  logic [bmm_pkg::WORD_W-1:0] acc;
  logic [bmm_pkg::SUM_W-1:0]  rsum, csum;
  logic [bmm_pkg::END_W-1:0]  rend_new, cend_new;
  logic [bmm_pkg::END_W-1:0]  c_inc, r_inc;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (st_r == S_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign in_addr = {in_row, in_col};
  assign a_raddr = {r_r, k_r};
  assign b_raddr = {k_r, c_r};
  assign rc_addr = {r_r, c_r};

  assign a_we    = in_acc && (in_action == bmm_pkg::ACT_WR_A);
  assign b_we    = in_acc && (in_action == bmm_pkg::ACT_WR_B);
  assign issue   = (st_r == S_MAC);
  assign mac_clr = issue && (k_r == '0);
  assign c_we    = (st_r == S_DRAIN) && (drain_r == 2'd2);

  // Block bounds, clipped at the matrix edge.
  assign rsum     = bmm_pkg::SUM_W'(in_row) + bmm_pkg::SUM_W'(edge_r);
  assign csum     = bmm_pkg::SUM_W'(in_col) + bmm_pkg::SUM_W'(edge_r);
  assign rend_new = (rsum > DIM_S) ? bmm_pkg::END_W'(bmm_pkg::DIM) : rsum[bmm_pkg::END_W-1:0];
  assign cend_new = (csum > DIM_S) ? bmm_pkg::END_W'(bmm_pkg::DIM) : csum[bmm_pkg::END_W-1:0];
  assign c_inc    = bmm_pkg::END_W'(c_r) + 1'b1;
  assign r_inc    = bmm_pkg::END_W'(r_r) + 1'b1;

  // Matrix memories: one write port and one registered read port each.
  always_ff @(posedge clk) begin
    if (a_we) begin
      mem_a[in_addr] <= in_value;
    end
    a_rd_r <= mem_a[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      mem_b[in_addr] <= in_value;
    end
    b_rd_r <= mem_b[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      mem_c[rc_addr] <= acc;
    end
    c_rd_r <= mem_c[in_addr];
  end

  // Shared multiply-accumulate unit.
  bmm_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (mac_clr),
    .in_valid (rd_v_r),
    .a        (a_rd_r),
    .b        (b_rd_r),
    .acc      (acc)
  );

  // Sequencer next state.
  always_comb begin
    st_nxt        = st_r;
    edge_nxt      = edge_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    k_nxt         = k_r;
    left_nxt      = left_r;
    rend_nxt      = rend_r;
    cend_nxt      = cend_r;
    drain_nxt     = drain_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_val_nxt   = out_val_r;

    if (cfg_valid && cfg_ready) begin
      edge_nxt = cfg_data;
    end

    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          out_kind_nxt = in_action;
          out_val_nxt  = '0;
          case (in_action)
            bmm_pkg::ACT_RD_C: begin
              st_nxt = S_RDC;
            end
            bmm_pkg::ACT_CMP: begin
              if (edge_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                st_nxt   = S_MAC;
                r_nxt    = in_row;
                c_nxt    = in_col;
                left_nxt = in_col;
                k_nxt    = '0;
                rend_nxt = rend_new;
                cend_nxt = cend_new;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_RDC: begin
        out_valid_nxt = 1'b1;
        out_val_nxt   = c_rd_r;
        st_nxt        = S_IDLE;
      end
      S_MAC: begin
        k_nxt = k_r + 1'b1;
        if (k_r == K_LAST) begin
          st_nxt    = S_DRAIN;
          drain_nxt = '0;
        end
      end
      S_DRAIN: begin
        drain_nxt = drain_r + 1'b1;
        if (drain_r == 2'd2) begin
          // Element done; step to the next column, then the next row.
          if (c_inc < cend_r) begin
            c_nxt  = c_r + 1'b1;
            st_nxt = S_MAC;
          end else if (r_inc < rend_r) begin
            r_nxt  = r_r + 1'b1;
            c_nxt  = left_r;
            st_nxt = S_MAC;
          end else begin
            st_nxt        = S_IDLE;
            out_valid_nxt = 1'b1;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      edge_r      <= bmm_pkg::EDGE_RESET;
      drain_r     <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      st_r        <= st_nxt;
      edge_r      <= edge_nxt;
      drain_r     <= drain_nxt;
      rd_v_r      <= issue;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
    end
    r_r        <= r_nxt;
    c_r        <= c_nxt;
    left_r     <= left_nxt;
    rend_r     <= rend_nxt;
    cend_r     <= cend_nxt;
    out_kind_r <= out_kind_nxt;
    out_val_r  <= out_val_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_kind_r;

  // A new beat is taken only while the sequencer is idle.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (st_r == S_IDLE))
    else $error("input ready outside idle");

  // A read of C answers on the cycle after its memory read.
  a_read_answers: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_action == bmm_pkg::ACT_RD_C) |=> ##1 out_tvalid)
    else $error("read of C did not answer");

  // The last dot-product term leads into the drain.
  a_k_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_MAC) && (k_r == K_LAST) |=> (st_r == S_DRAIN) && (drain_r == 2'd0))
    else $error("dot product did not drain");

  // A C write happens only with no result pending from this item.
  a_cwrite_out: assert property (@(posedge clk) disable iff (!rst_n)
    c_we |-> !out_valid_r)
    else $error("C written while a result was pending");

  // A compute with a nonzero edge starts the multiply loop.
  a_cmp_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_action == bmm_pkg::ACT_CMP) && (edge_r != '0) |=> (st_r == S_MAC))
    else $error("compute did not start");

endmodule

`default_nettype wire

// ===== tb/blocked_matrix_multiply_core_tb.sv =====
// Self-checking testbench for blocked_matrix_multiply_core: loads A and B, computes blocks
// of C under several block edges, reads C back and checks every result beat in order.
// Depends on bmm_pkg and the core RTL only.
`timescale 1ns / 1ps

module blocked_matrix_multiply_core_tb;

  localparam int CELLS = bmm_pkg::DIM * bmm_pkg::DIM;

  // First and last of the rows of A and the columns of B that computes may read.
  localparam int LOAD_LO = bmm_pkg::DIM - 2;
  localparam int LOAD_HI = bmm_pkg::DIM - 1;

  typedef struct packed {
    logic [bmm_pkg::ACT_W-1:0]  kind;
    logic [bmm_pkg::WORD_W-1:0] value;
  } result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [bmm_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [bmm_pkg::ACT_W-1:0]     in_tuser = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [bmm_pkg::WORD_W-1:0]    out_tdata;
  logic [bmm_pkg::ACT_W-1:0]     out_tuser;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [bmm_pkg::EDGE_W-1:0]    cfg_data = '0;

  // Shadow copy of the matrices and the block edge register.
  logic [bmm_pkg::WORD_W-1:0] a_mem [0:CELLS-1];
  logic [bmm_pkg::WORD_W-1:0] b_mem [0:CELLS-1];
  logic [bmm_pkg::WORD_W-1:0] c_mem [0:CELLS-1];
  bit                         c_written [0:CELLS-1];
  int                         c_cells [$];
  logic [bmm_pkg::EDGE_W-1:0] edge_len;

  result_t pending_results [$];
  bit      idle_on = 1'b1;
  int      sink_stall = 0;
  int      errors = 0;
  int      beats_sent = 0;
  int      results_checked = 0;
  int      blocks_computed = 0;
  int      cells_computed = 0;

  blocked_matrix_multiply_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // row[5:0], col[11:6], value[43:12]
    .in_tuser   (in_tuser),   // action[1:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // read_value[31:0]
    .out_tuser  (out_tuser),  // kind[1:0]
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Clock: 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result sink: random stall bursts unless idling is off.
  always @(negedge clk) begin
    if (!idle_on) begin
      out_tready <= 1'b1;
    end else if (sink_stall != 0) begin
      sink_stall <= sink_stall - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      sink_stall <= $urandom_range(0, 8);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each result beat against the oldest pending expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat kind=%0d value=%h", $time, out_tuser,
                 out_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_tuser !== want.kind) begin
          $display("%0t: kind mismatch, expected %0d actual %0d", $time, want.kind,
                   out_tuser);
          errors++;
        end
        if (out_tdata !== want.value) begin
          $display("%0t: read_value mismatch (kind %0d), expected %h actual %h", $time,
                   want.kind, want.value, out_tdata);
          errors++;
        end
      end
    end
  end

  // Recompute a block of C, clipped at the matrix edge; sums wrap at 32 bits.
  task automatic predict_block(input int top, input int left);
    int r_end;
    int c_end;
    int idx;
    logic [bmm_pkg::WORD_W-1:0] acc;
    r_end = (top + edge_len > bmm_pkg::DIM) ? bmm_pkg::DIM : top + edge_len;
    c_end = (left + edge_len > bmm_pkg::DIM) ? bmm_pkg::DIM : left + edge_len;
    for (int r = top; r < r_end; r++) begin
      for (int c = left; c < c_end; c++) begin
        acc = '0;
        for (int k = 0; k < bmm_pkg::DIM; k++)
          acc = acc + a_mem[r * bmm_pkg::DIM + k] * b_mem[k * bmm_pkg::DIM + c];
        idx = r * bmm_pkg::DIM + c;
        c_mem[idx] = acc;
        cells_computed++;
        if (!c_written[idx]) begin
          c_written[idx] = 1'b1;
          c_cells.push_back(idx);
        end
      end
    end
    blocks_computed++;
  endtask

  // Send one beat, then update the shadow state and queue its expected result.
  task automatic send_item(input logic [bmm_pkg::ACT_W-1:0] act, input int row,
                           input int col, input logic [bmm_pkg::WORD_W-1:0] value);
    int gap;
    int idx;
    logic [bmm_pkg::IDX_W-1:0] r_f;
    logic [bmm_pkg::IDX_W-1:0] c_f;
    result_t want;
    r_f = bmm_pkg::IDX_W'(row);
    c_f = bmm_pkg::IDX_W'(col);
    idx = int'({r_f, c_f});
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= bmm_pkg::IN_DATA_W'({value, c_f, r_f});
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    want.kind  = act;
    want.value = '0;
    case (act)
      bmm_pkg::ACT_WR_A: a_mem[idx] = value;
      bmm_pkg::ACT_WR_B: b_mem[idx] = value;
      bmm_pkg::ACT_CMP:  predict_block(int'(r_f), int'(c_f));
      default:           want.value = c_mem[idx];
    endcase
    pending_results.push_back(want);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the block edge register while the core is idle.
  task automatic set_block_edge(input logic [bmm_pkg::EDGE_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    edge_len = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [bmm_pkg::WORD_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Fill the two bottom rows of A and the two right columns of B. Every nonzero-edge
  // compute has its corner in that bottom-right square, so none reads an unwritten entry.
  task automatic load_matrices;
    for (int k = 0; k < bmm_pkg::DIM; k++) begin
      send_item(bmm_pkg::ACT_WR_A, LOAD_LO, k, pick_value());
      send_item(bmm_pkg::ACT_WR_A, LOAD_HI, k, pick_value());
      send_item(bmm_pkg::ACT_WR_B, k, LOAD_LO, pick_value());
      send_item(bmm_pkg::ACT_WR_B, k, LOAD_HI, pick_value());
    end
  endtask

  // Extreme operands, reset block edge, clipping, edge zero and oversized edges.
  task automatic test_directed;
    send_item(bmm_pkg::ACT_WR_A, 62, 0, 32'h7FFF_FFFF);
    send_item(bmm_pkg::ACT_WR_A, 62, 1, 32'h8000_0000);
    send_item(bmm_pkg::ACT_WR_A, 62, 2, 32'hFFFF_FFFF);
    send_item(bmm_pkg::ACT_WR_B, 0, 62, 32'hFFFF_FFFF);
    send_item(bmm_pkg::ACT_WR_B, 1, 62, 32'h8000_0000);
    send_item(bmm_pkg::ACT_WR_B, 2, 62, 32'h7FFF_FFFF);
    send_item(bmm_pkg::ACT_WR_A, 63, 63, 32'h8000_0000);
    send_item(bmm_pkg::ACT_WR_B, 63, 63, 32'h8000_0000);
    // Reset edge of 32 clipped to two by two, then a block clipped to one element.
    send_item(bmm_pkg::ACT_CMP, 62, 62, $urandom);
    send_item(bmm_pkg::ACT_CMP, 63, 63, $urandom);
    send_item(bmm_pkg::ACT_RD_C, 62, 62, $urandom);
    send_item(bmm_pkg::ACT_RD_C, 62, 63, $urandom);
    send_item(bmm_pkg::ACT_RD_C, 63, 63, $urandom);
    // An edge of zero leaves C untouched, wherever the corner lies.
    set_block_edge(7'd0);
    send_item(bmm_pkg::ACT_WR_A, 62, 7, 32'h1234_5678);
    send_item(bmm_pkg::ACT_CMP, 5, 5, $urandom);
    send_item(bmm_pkg::ACT_CMP, 62, 62, $urandom);
    send_item(bmm_pkg::ACT_RD_C, 62, 62, $urandom);
    // Edges of 127 and 64 are clipped at the matrix edge.
    set_block_edge(7'd127);
    send_item(bmm_pkg::ACT_CMP, 62, 63, $urandom);
    send_item(bmm_pkg::ACT_RD_C, 63, 63, $urandom);
    send_item(bmm_pkg::ACT_RD_C, 62, 63, $urandom);
    set_block_edge(7'd64);
    send_item(bmm_pkg::ACT_CMP, 62, 62, $urandom);
    send_item(bmm_pkg::ACT_RD_C, 63, 62, $urandom);
    send_item(bmm_pkg::ACT_RD_C, 62, 63, $urandom);
  endtask

  // Random mix of loads, computes and reads of computed C entries.
  task automatic test_random(input int count, input logic [bmm_pkg::EDGE_W-1:0] block);
    int pick;
    int idx;
    set_block_edge(block);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_item(bmm_pkg::ACT_WR_A, $urandom, $urandom, pick_value());
      end else if (pick < 70) begin
        send_item(bmm_pkg::ACT_WR_B, $urandom, $urandom, pick_value());
      end else if (pick < 80) begin
        send_item(bmm_pkg::ACT_CMP, LOAD_LO + $urandom_range(0, 1),
                  LOAD_LO + $urandom_range(0, 1), $urandom);
      end else begin
        idx = c_cells[$urandom_range(0, c_cells.size() - 1)];
        send_item(bmm_pkg::ACT_RD_C, idx / bmm_pkg::DIM, idx % bmm_pkg::DIM, $urandom);
      end
    end
  endtask

  initial begin
    edge_len = bmm_pkg::EDGE_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_matrices();
    test_directed();
    test_random(50, 7'd1);
    test_random(40, 7'd4);
    test_random(30, 7'd8);
    // Last stretch runs with no idling on either side.
    drain();
    idle_on = 1'b0;
    test_random(50, 7'd2);
    drain();
    repeat (20) @(posedge clk);

    $display("Run covered %0d input beats and %0d checked results, with %0d block computes",
             beats_sent, results_checked, blocks_computed);
    $display("producing %0d C elements, with block edges 0, 1, 2, 4, 8, 32, 64 and 127.",
             cells_computed);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
